### hdl/scored_ring_buffer_with_pruning_macros.svh
// assertion macros for the scored ring buffer
`ifndef SCORED_RING_BUFFER_WITH_PRUNING_MACROS_SVH
`define SCORED_RING_BUFFER_WITH_PRUNING_MACROS_SVH

// implication checked on every clock edge outside reset
`define SRB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/srb_pkg.sv
// shared constants and codes for the scored ring buffer
`timescale 1ns / 1ps
package srb_pkg;
  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned AW           = $clog2(DEPTH);
  localparam int unsigned CW           = AW + 1;
  localparam int unsigned PAYLOAD_BITS = 64;

  localparam logic [2:0] FN_BEGIN    = 3'd0;
  localparam logic [2:0] FN_CONSUME  = 3'd1;
  localparam logic [2:0] FN_ADD      = 3'd2;
  localparam logic [2:0] FN_PRUNE    = 3'd3;
  localparam logic [2:0] FN_FINALIZE = 3'd4;
  localparam logic [2:0] FN_BEST     = 3'd5;
  localparam logic [2:0] FN_CLEAR    = 3'd6;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_PHASE = 3'd3;
  localparam logic [2:0] ST_OLD   = 3'd4;

  // ring increment with wrap at the capacity in use
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s,
                                              input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = {1'b0, s} + CW'(1);
    next_slot = (n >= c) ? '0 : n[AW-1:0];
  endfunction
endpackage

### hdl/scored_ring_buffer_with_pruning.sv
// scored ring buffer with threshold pruning, top level
// A command is taken at a rising edge with start high and busy low, and every command
// returns exactly one result beat. The beat is on out_valid for one cycle and the
// receiver cannot stall it, so every beat must be taken. Each command passes through:
// - begin, consume, finalize, clear, the unused code, every rejected command and a
//   prune of an empty region go from idle straight to the done state.
// - add passes through S_ADD, which writes the entry memory, before the done state.
// - prune and best on a non-empty region pass through S_WALK. They walk the region
//   through the single-read-port entry memory at one entry a cycle, and the memory
//   read is registered, so the walk ends once the last read data has come back.
// busy is high from the accepting edge until the result beat is driven; the beat
// is on out_valid in the first cycle with busy low again. A configuration write is
// taken only while idle with start low. It sets the capacity and clears the store
// pointers.
`timescale 1ns / 1ps
`include "scored_ring_buffer_with_pruning_macros.svh"
module scored_ring_buffer_with_pruning
  import srb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_func,
  input  logic [63:0]             in_payload,
  input  logic signed [31:0]      in_score,
  input  logic signed [31:0]      in_threshold,
  input  logic [10:0]             in_count,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [63:0]             out_best_payload,
  output logic signed [31:0]      out_best_score,
  output logic [10:0]             out_current_count,
  output logic [10:0]             out_old_remaining,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [10:0]             cfg_data
);
  typedef enum logic [1:0] {S_IDLE, S_ADD, S_WALK, S_DONE} state_t;
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] pay;
    logic signed [31:0]      scr;
  } entry_t;

  // entry memory
  entry_t mem [DEPTH];
  entry_t rd_r;
  logic [AW-1:0] rd_addr;
  logic we;
  logic [AW-1:0] wa;
  entry_t wd;

  state_t state_r;
  logic [10:0] cap_r;
  logic [AW-1:0] head_r, wstart_r, wslot_r;
  logic [CW-1:0] region_r, old_r, cons_r;
  logic upd_r;
  logic [2:0] fn_r;
  logic signed [31:0] thr_r;
  entry_t add_r;
  logic [CW-1:0] left_r, kept_r;
  logic [AW-1:0] rp_r, wp_r;
  logic rd_v_r;
  entry_t best_r;

  logic [CW-1:0] cap;
  assign cap = (cap_r == '0) ? CW'(1) :
               ((cap_r > CW'(DEPTH)) ? CW'(DEPTH) : cap_r[CW-1:0]);

  logic acc;
  assign acc = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;

  // modulo for values below twice the capacity
  function automatic logic [AW-1:0] wrap(input logic [CW:0] v, input logic [CW-1:0] c);
    wrap = (v >= {1'b0, c}) ? AW'(v - {1'b0, c}) : v[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  // read address is always the walk pointer; writes come from add or a prune walk
  always_comb begin
    rd_addr = rp_r;
    we = 1'b0;
    wa = wp_r;
    wd = rd_r;
    if (state_r == S_ADD) begin
      we = 1'b1;
      wa = wslot_r;
      wd = add_r;
    end else if (state_r == S_WALK && rd_v_r && fn_r == FN_PRUNE &&
                 rd_r.scr > thr_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 11'(DEPTH);
      head_r <= '0; wstart_r <= '0; wslot_r <= '0;
      region_r <= '0; old_r <= '0; cons_r <= '0; upd_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            cap_r <= cfg_data;
            head_r <= '0; wstart_r <= '0; wslot_r <= '0;
            region_r <= '0; old_r <= '0; cons_r <= '0; upd_r <= 1'b0;
          end else if (acc) begin
            fn_r <= in_func;
            thr_r <= in_threshold;
            add_r.pay <= in_payload[PAYLOAD_BITS-1:0];
            add_r.scr <= in_score;
            out_status <= ST_OK;
            out_best_payload <= '0;
            out_best_score <= '0;
            state_r <= S_DONE;
            case (in_func)
              FN_BEGIN: begin
                if (upd_r) out_status <= ST_PHASE;
                else begin
                  old_r <= region_r;
                  wstart_r <= wrap({1'b0, CW'(head_r)} + {1'b0, region_r}, cap);
                  wslot_r <= wrap({1'b0, CW'(head_r)} + {1'b0, region_r}, cap);
                  region_r <= '0; cons_r <= '0; upd_r <= 1'b1;
                end
              end
              FN_CONSUME: begin
                if ({1'b0, cons_r} + {1'b0, in_count} > {1'b0, old_r})
                  out_status <= ST_OLD;
                else cons_r <= cons_r + in_count;
              end
              FN_ADD: begin
                if (!upd_r) out_status <= ST_PHASE;
                else if ((old_r - cons_r) + region_r >= cap) out_status <= ST_FULL;
                else begin
                  wslot_r <= wrap({1'b0, CW'(wslot_r)}, cap);
                  state_r <= S_ADD;
                end
              end
              FN_PRUNE: begin
                if (!upd_r) out_status <= ST_PHASE;
                else if (region_r != '0) begin
                  rp_r <= wrap({1'b0, CW'(wstart_r)}, cap);
                  wp_r <= wrap({1'b0, CW'(wstart_r)}, cap);
                  left_r <= region_r; kept_r <= '0; rd_v_r <= 1'b0;
                  state_r <= S_WALK;
                end
              end
              FN_FINALIZE: begin
                if (!upd_r) out_status <= ST_PHASE;
                else if (cons_r != old_r) out_status <= ST_OLD;
                else begin
                  head_r <= wstart_r; old_r <= '0; cons_r <= '0;
                  upd_r <= 1'b0; wslot_r <= '0; wstart_r <= '0;
                end
              end
              FN_BEST: begin
                if (region_r == '0) out_status <= ST_EMPTY;
                else begin
                  rp_r <= wrap({1'b0, CW'(upd_r ? wstart_r : head_r)}, cap);
                  left_r <= region_r; kept_r <= '0; rd_v_r <= 1'b0;
                  state_r <= S_WALK;
                end
              end
              FN_CLEAR: begin
                head_r <= '0; wstart_r <= '0; wslot_r <= '0;
                region_r <= '0; old_r <= '0; cons_r <= '0; upd_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          wslot_r <= next_slot(wslot_r, cap);
          region_r <= region_r + CW'(1);
          state_r <= S_DONE;
        end
        S_WALK: begin
          // issue reads while entries remain
          if (left_r != '0) begin
            rp_r <= next_slot(rp_r, cap);
            left_r <= left_r - CW'(1);
          end
          rd_v_r <= (left_r != '0);
          if (rd_v_r) begin
            if (fn_r == FN_PRUNE) begin
              if (rd_r.scr > thr_r) begin
                wp_r <= next_slot(wp_r, cap);
                kept_r <= kept_r + CW'(1);
              end
            end else if (kept_r == '0 || rd_r.scr > best_r.scr) begin
              best_r <= rd_r;
              kept_r <= CW'(1);
            end
          end
          if (left_r == '0 && rd_v_r) begin
            state_r <= S_DONE;
            if (fn_r == FN_PRUNE) begin
              region_r <= kept_r + CW'(rd_r.scr > thr_r);
              wslot_r <= (rd_r.scr > thr_r) ? next_slot(wp_r, cap) : wp_r;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (fn_r == FN_BEST && region_r != '0) begin
            out_best_payload <= 64'(best_r.pay);
            out_best_score <= best_r.scr;
          end
          out_current_count <= 11'(region_r);
          out_old_remaining <= 11'(old_r - cons_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // add that fits and goes on to the memory write
  logic add_go;
  assign add_go = acc && in_func == FN_ADD && upd_r && ((old_r - cons_r) + region_r < cap);

  `SRB_ASSERT_NEXT(a_add_two, add_go, state_r == S_ADD)
  `SRB_ASSERT_IMP(a_region_cap, state_r == S_IDLE, region_r <= CW'(DEPTH))
  `SRB_ASSERT_IMP(a_cons_old, state_r == S_IDLE, cons_r <= old_r)
  `SRB_ASSERT_NEXT(a_done_out, state_r == S_DONE, out_valid && !busy)
endmodule

### tb/sv/scored_ring_buffer_with_pruning_chk.sv
// checker for the scored ring buffer: predicts each result beat and compares it
`timescale 1ns / 1ps
module scored_ring_buffer_with_pruning_chk
  import srb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_func,
  input  logic [63:0]        in_payload,
  input  logic signed [31:0] in_score,
  input  logic signed [31:0] in_threshold,
  input  logic [10:0]        in_count,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [63:0]        out_best_payload,
  input  logic signed [31:0] out_best_score,
  input  logic [10:0]        out_current_count,
  input  logic [10:0]        out_old_remaining,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 beats_seen
);
  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        bpay;
    logic signed [31:0] bscore;
    logic [10:0]        cur;
    logic [10:0]        old_left;
  } result_t;

  result_t expected_q[$];

  // shadow of the store
  logic [63:0]        pay_mem [DEPTH];
  logic signed [31:0] score_mem [DEPTH];
  int unsigned head, wstart, wslot, region, old_n, consumed, cap_reg;
  bit updating;

  function automatic int unsigned cap_eff();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned step_slot(int unsigned s, int unsigned c);
    s++;
    return (s >= c) ? 0 : s;
  endfunction

  function automatic void clear_pointers();
    head = 0; wstart = 0; wslot = 0; region = 0;
    old_n = 0; consumed = 0; updating = 0;
  endfunction

  // compute the result of one command and update the shadow
  function automatic result_t apply_command(logic [2:0] fn, logic [63:0] pay,
      logic signed [31:0] sc, logic signed [31:0] thr, logic [10:0] cnt);
    result_t r;
    int unsigned c, rd, wr, kept, s, best_at;
    c = cap_eff();
    r = '0;
    r.status = ST_OK;
    case (fn)
      FN_BEGIN: begin
        if (updating) r.status = ST_PHASE;
        else begin
          old_n = region;
          wstart = (head + region) % c;
          wslot = wstart;
          region = 0; consumed = 0; updating = 1;
        end
      end
      FN_CONSUME: begin
        if (consumed + cnt > old_n) r.status = ST_OLD;
        else consumed += cnt;
      end
      FN_ADD: begin
        if (!updating) r.status = ST_PHASE;
        else if ((old_n - consumed) + region >= c) r.status = ST_FULL;
        else begin
          pay_mem[wslot % c] = pay;
          score_mem[wslot % c] = sc;
          wslot = step_slot(wslot % c, c);
          region++;
        end
      end
      FN_PRUNE: begin
        if (!updating) r.status = ST_PHASE;
        else if (region != 0) begin
          rd = wstart % c; wr = rd; kept = 0;
          for (int i = 0; i < region; i++) begin
            if (score_mem[rd] > thr) begin
              pay_mem[wr] = pay_mem[rd];
              score_mem[wr] = score_mem[rd];
              kept++;
              wr = step_slot(wr, c);
            end
            rd = step_slot(rd, c);
          end
          region = kept;
          wslot = wr;
        end
      end
      FN_FINALIZE: begin
        if (!updating) r.status = ST_PHASE;
        else if (consumed != old_n) r.status = ST_OLD;
        else begin
          head = wstart; old_n = 0; consumed = 0; updating = 0;
          wslot = 0; wstart = 0;
        end
      end
      FN_BEST: begin
        if (region == 0) r.status = ST_EMPTY;
        else begin
          s = (updating ? wstart : head) % c;
          best_at = s;
          for (int i = 0; i < region; i++) begin
            if (score_mem[s] > score_mem[best_at]) best_at = s;
            s = step_slot(s, c);
          end
          r.bpay = pay_mem[best_at];
          r.bscore = score_mem[best_at];
        end
      end
      FN_CLEAR: clear_pointers();
      default: ;
    endcase
    r.cur = region[10:0];
    r.old_left = 11'(old_n - consumed);
    return r;
  endfunction

  // watch config writes, command beats and result beats
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      clear_pointers();
      cap_reg = DEPTH;
      fail_count <= 0;
      beats_seen <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_status, out_best_payload, out_best_score,
                out_current_count, out_old_remaining};
        beats_seen <= beats_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        clear_pointers();
      end
      if (start && !busy)
        expected_q.push_back(apply_command(in_func, in_payload, in_score,
                                           in_threshold, in_count));
    end
    pending <= expected_q.size();
  end
endmodule

### tb/sv/scored_ring_buffer_with_pruning_tb.sv
// testbench top: drives commands and capacity writes, reports the verdict
`timescale 1ns / 1ps
module scored_ring_buffer_with_pruning_tb
  import srb_pkg::*;
();

  localparam int CYCLE_LIMIT = 5000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic [2:0]         in_func = FN_CLEAR;
  logic [63:0]        in_payload = '0;
  logic signed [31:0] in_score = '0;
  logic signed [31:0] in_threshold = '0;
  logic [10:0]        in_count = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [63:0]        out_best_payload;
  logic signed [31:0] out_best_score;
  logic [10:0]        out_current_count;
  logic [10:0]        out_old_remaining;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [10:0]        cfg_data = '0;
  int                 fail_count, pending, beats_seen;
  int                 cycles = 0;
  int                 cmds_sent = 0;
  int                 cap_writes = 0;
  int unsigned        cap_now = DEPTH;

  always #10 clk = ~clk;

  scored_ring_buffer_with_pruning u_top (.*);

  scored_ring_buffer_with_pruning_chk u_chk (.*);

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** scored_ring_buffer_with_pruning: FAILED **");
      $finish;
    end
  end

  // one command beat, held until accepted
  task automatic send_cmd(logic [2:0] fn, logic [63:0] pay,
                          logic signed [31:0] sc, logic signed [31:0] thr,
                          logic [10:0] cnt);
    in_func = fn; in_payload = pay; in_score = sc;
    in_threshold = thr; in_count = cnt; start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 0;
    cmds_sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cap(logic [10:0] v);
    drain();
    cfg_data <= v; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    cap_now = (v == 0) ? 1 : (v > DEPTH ? DEPTH : v);
    cap_writes++;
  endtask

  function automatic logic signed [31:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // random bursts with gaps between them
  task automatic gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // round: begin, consume, adds, maybe prune, any command, finalize, best
  task automatic round(int unsigned old_left);
    int n;
    send_cmd(FN_BEGIN, 0, 0, 0, 0);
    while (old_left != 0) begin
      n = $urandom_range(0, old_left);
      send_cmd(FN_CONSUME, 0, 0, 0, 11'(n));
      old_left -= n;
      gap();
    end
    n = $urandom_range(1, (cap_now > 24) ? 24 : cap_now + 1);
    repeat (n) begin
      send_cmd(FN_ADD, {$urandom, $urandom}, rand_score(), 0, 0);
      gap();
      if ($urandom_range(0, 7) == 0) send_cmd(FN_BEST, 0, 0, 0, 0);
    end
    if ($urandom_range(0, 2) == 0) send_cmd(FN_PRUNE, 0, 0, rand_score(), 0);
    if ($urandom_range(0, 4) == 0) send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(3'($urandom_range(0, 7)), {$urandom, $urandom}, rand_score(),
             rand_score(), 11'($urandom));
    send_cmd(FN_CONSUME, 0, 0, 0, 0);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(FN_BEST, 0, 0, 0, 0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: wrong phase, empty best, extremes, pruning, overconsume
    send_cmd(FN_ADD, '1, 0, 0, 0);
    send_cmd(FN_PRUNE, 0, 0, 0, 0);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(FN_BEST, 0, 0, 0, 0);
    send_cmd(3'd7, '1, '1, '1, '1);
    send_cmd(FN_BEGIN, 0, 0, 0, 0);
    send_cmd(FN_BEGIN, 0, 0, 0, 0);
    send_cmd(FN_PRUNE, 0, 0, 0, 0);
    send_cmd(FN_CONSUME, 0, 0, 0, 11'd1);
    send_cmd(FN_CONSUME, 0, 0, 0, 11'h7ff);
    send_cmd(FN_ADD, 64'hffff_ffff_ffff_ffff, 32'sh7fff_ffff, 0, 0);
    send_cmd(FN_ADD, 64'h0, 32'sh8000_0000, 0, 0);
    send_cmd(FN_ADD, 64'h5555_aaaa_5555_aaaa, 32'sh7fff_ffff, 0, 0);
    send_cmd(FN_BEST, 0, 0, 0, 0);
    send_cmd(FN_PRUNE, 0, 0, 32'sh8000_0000, 0);
    send_cmd(FN_PRUNE, 0, 0, 32'sh7fff_fffe, 0);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(FN_BEGIN, 0, 0, 0, 0);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(FN_CONSUME, 0, 0, 0, 11'd3);
    send_cmd(FN_CONSUME, 0, 0, 0, 11'd2);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    send_cmd(FN_BEST, 0, 0, 0, 0);
    send_cmd(FN_CLEAR, 0, 0, 0, 0);

    // full test at capacity 1, then random rounds over several capacities
    write_cap(11'd1);
    send_cmd(FN_BEGIN, 0, 0, 0, 0);
    send_cmd(FN_ADD, 64'h1, 32'sd5, 0, 0);
    send_cmd(FN_ADD, 64'h2, 32'sd6, 0, 0);
    send_cmd(FN_FINALIZE, 0, 0, 0, 0);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_cap(11'd0);
        1: write_cap(11'd2);
        2: write_cap(11'd7);
        3: write_cap(11'd1024);
        4: write_cap(11'd2047);
        default: write_cap(11'($urandom_range(3, 40)));
      endcase
      while (cmds_sent < 110 * (ph + 1) + 30) begin
        // begin after a finalize: old region is the last region
        round(u_chk.region);
        gap();
      end
    end
    drain();
    $display("run sent %0d commands, checked %0d result beats", cmds_sent, beats_seen);
    $display("capacity was rewritten %0d times, extremes included", cap_writes);
    if (fail_count == 0)
      $display("** scored_ring_buffer_with_pruning: PASSED **");
    else
      $display("** scored_ring_buffer_with_pruning: FAILED **");
    $finish;
  end
endmodule
